[hdl/mvd_pkg.sv]
package mvd_pkg;

  localparam int MAX_HALF_WIDTH = 64;
  localparam int SAMPLE_BITS    = 16;
  localparam int INDEX_BITS     = 20;

  // config register width is fixed by the register map
  localparam int HW_BITS  = 7;
  // run counters saturate at MAX_HALF_WIDTH
  localparam int RUN_BITS = $clog2(MAX_HALF_WIDTH + 1);
  // number of cells in the falling-run delay line
  localparam int NUM_CELLS = MAX_HALF_WIDTH;

  localparam logic [RUN_BITS-1:0]   RUN_MAX   = RUN_BITS'(MAX_HALF_WIDTH);
  localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   end_of_sequence;
  } in_item_t;

  typedef struct packed {
    logic                  good_day;
    logic [INDEX_BITS-1:0] day_index;
    logic                  sequence_end;
    logic                  index_overflow;
  } out_item_t;

endpackage

[hdl/mvd_cell.sv]
// One stage of the falling-run delay line. Holds the run length of one past
// position, passes it on each item and flags a hit when it is the selected tap and its run is at least half_width.
module mvd_cell (
  input  logic                         clk,
  input  logic                         shift_en,
  input  logic [mvd_pkg::RUN_BITS-1:0] din,
  input  logic [mvd_pkg::RUN_BITS-1:0] half_width,
  input  logic                         tap_sel,
  output logic [mvd_pkg::RUN_BITS-1:0] dout,
  output logic                         hit
);

  logic [mvd_pkg::RUN_BITS-1:0] run_r;
  logic [mvd_pkg::RUN_BITS-1:0] run_nxt;

  always_comb begin
    run_nxt = shift_en ? din : run_r;
  end

  always_ff @(posedge clk) begin
    run_r <= run_nxt;
  end

  assign dout = run_r;
  assign hit  = tap_sel & (run_r >= half_width);

endmodule

[hdl/monotone_valley_detector.sv]
// Valley detector over a stream of unsigned samples. One item goes in and one
// item comes out for each sample, one item per clock sustained unless out_stall
// holds a pending result, and results are registered. The result judges
// position pos - half_width of the current sequence: good_day is set when the
// half_width samples before it are non-increasing into it and the half_width
// samples after it are non-decreasing. Before the window fills, good_day and
// day_index are 0; half_width 0 marks every position; half_width above 64 acts
// as 64. The falling-run length of each recent position travels down a row of
// 64 cells, one cell per item, and the cell whose depth equals half_width is
// the tap compared. end_of_sequence clears all sequence state after its item.
// When the position counter reaches its top value, later items of the
// sequence report the top index with index_overflow set and good_day clear.
// Configuration (cfg_half_width) is always ready and should be written only
// while no item is in flight.
module monotone_valley_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  mvd_pkg::in_item_t             in_item,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output mvd_pkg::out_item_t            out_item,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mvd_pkg::HW_BITS-1:0]   cfg_half_width
);

  localparam int RB = mvd_pkg::RUN_BITS;
  localparam int IB = mvd_pkg::INDEX_BITS;
  localparam int NC = mvd_pkg::NUM_CELLS;

  // ---------------- configuration ----------------
  logic [mvd_pkg::HW_BITS-1:0] half_width_r;
  logic [mvd_pkg::HW_BITS-1:0] half_width_nxt;
  logic [RB-1:0]               h_eff;

  assign cfg_ready = 1'b1;

  always_comb begin
    half_width_nxt = (cfg_valid && cfg_ready) ? cfg_half_width : half_width_r;
  end

  // clamp to the delay line depth
  assign h_eff = (32'(half_width_r) > 32'(mvd_pkg::MAX_HALF_WIDTH))
               ? mvd_pkg::RUN_MAX : RB'(half_width_r);

  // ---------------- handshake ----------------
  logic in_acc;
  logic out_valid_r;
  logic out_valid_nxt;

  // output register frees up in the same cycle it is drained
  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    out_valid_nxt = in_acc | (out_valid_r & out_stall);
  end

  // ---------------- sequence state ----------------
  logic [mvd_pkg::SAMPLE_BITS-1:0] prev_r, prev_nxt;
  logic [RB-1:0]                   fall_r, fall_nxt;
  logic [RB-1:0]                   rise_r, rise_nxt;
  logic [IB-1:0]                   pos_r, pos_nxt;
  logic                            ovf_r, ovf_nxt;

  logic first_item;
  logic [RB-1:0] fall_new, rise_new;

  assign first_item = (pos_r == '0) & ~ovf_r;

  always_comb begin
    if (first_item) begin
      fall_new = '0;
      rise_new = '0;
    end else begin
      if (prev_r >= in_item.sample) begin
        fall_new = (fall_r >= mvd_pkg::RUN_MAX) ? mvd_pkg::RUN_MAX : fall_r + RB'(1);
      end else begin
        fall_new = '0;
      end
      if (prev_r <= in_item.sample) begin
        rise_new = (rise_r >= mvd_pkg::RUN_MAX) ? mvd_pkg::RUN_MAX : rise_r + RB'(1);
      end else begin
        rise_new = '0;
      end
    end
  end

  // ---------------- delay line of falling runs ----------------
  // cell k holds the falling run of position pos-1-k
  logic [RB-1:0] cell_out [NC];
  logic [NC-1:0] cell_hit;

  genvar k;
  generate
    for (k = 0; k < NC; k++) begin : g_cell
      logic [RB-1:0] cell_in;
      if (k == 0) begin : g_head
        assign cell_in = fall_new;
      end else begin : g_link
        assign cell_in = cell_out[k-1];
      end
      mvd_cell u_cell (
        .clk        (clk),
        .shift_en   (in_acc),
        .din        (cell_in),
        .half_width (h_eff),
        .tap_sel    (h_eff == RB'(k + 1)),
        .dout       (cell_out[k]),
        .hit        (cell_hit[k])
      );
    end
  endgenerate

  // ---------------- judgement ----------------
  logic               window_full;
  logic               good;
  logic [IB-1:0]      day;
  mvd_pkg::out_item_t res;
  mvd_pkg::out_item_t out_item_r, out_item_nxt;

  assign window_full = pos_r >= IB'(h_eff);

  always_comb begin
    good = 1'b0;
    day  = '0;
    if (ovf_r) begin
      day = mvd_pkg::INDEX_MAX;
    end else if (window_full) begin
      day  = pos_r - IB'(h_eff);
      good = (h_eff == '0) | ((|cell_hit) & (rise_new >= h_eff));
    end
    res.good_day       = good;
    res.day_index      = day;
    res.sequence_end   = in_item.end_of_sequence;
    res.index_overflow = ovf_r;
  end

  always_comb begin
    out_item_nxt = in_acc ? res : out_item_r;
  end

  assign out_item = out_item_r;

  // ---------------- state update ----------------
  always_comb begin
    prev_nxt = prev_r;
    fall_nxt = fall_r;
    rise_nxt = rise_r;
    pos_nxt  = pos_r;
    ovf_nxt  = ovf_r;
    if (in_acc) begin
      if (in_item.end_of_sequence) begin
        prev_nxt = '0;
        fall_nxt = '0;
        rise_nxt = '0;
        pos_nxt  = '0;
        ovf_nxt  = 1'b0;
      end else begin
        prev_nxt = in_item.sample;
        fall_nxt = fall_new;
        rise_nxt = rise_new;
        if (!ovf_r) begin
          if (pos_r == mvd_pkg::INDEX_MAX) begin
            ovf_nxt = 1'b1;
          end else begin
            pos_nxt = pos_r + IB'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r <= '0;
      out_valid_r  <= 1'b0;
      prev_r       <= '0;
      fall_r       <= '0;
      rise_r       <= '0;
      pos_r        <= '0;
      ovf_r        <= 1'b0;
    end else begin
      half_width_r <= half_width_nxt;
      out_valid_r  <= out_valid_nxt;
      prev_r       <= prev_nxt;
      fall_r       <= fall_nxt;
      rise_r       <= rise_nxt;
      pos_r        <= pos_nxt;
      ovf_r        <= ovf_nxt;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

endmodule
